/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// Check that a consequent follows an antecedent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a consequent follows an antecedent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/tkh_pkg.sv */
package tkh_pkg;

    localparam int HEAP_DEPTH_DEF = 64;
    localparam int TAG_BITS_DEF   = 32;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int TAG_IN_W = 32;
    localparam int SLOT_W   = 6;
    localparam int KEEP_W   = 7;
    localparam int HELD_W   = 7;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_OFFER = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

endpackage

/* hw/rtl/tkh_ifs.sv */
interface tkh_item_if;
    logic                                  valid;
    logic                                  ready;
    logic        [tkh_pkg::OP_W-1:0]      op;
    logic signed [tkh_pkg::KEY_W-1:0]     key;
    logic        [tkh_pkg::TAG_IN_W-1:0]  tag_id;
    logic        [tkh_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, op, key, tag_id, slot, input ready);
    modport sink   (input valid, op, key, tag_id, slot, output ready);
endinterface

interface tkh_res_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  accepted;
    logic signed [tkh_pkg::KEY_W-1:0]     min_key;
    logic        [tkh_pkg::HELD_W-1:0]    held_count;
    logic                                  read_valid;
    logic signed [tkh_pkg::KEY_W-1:0]     read_key;
    logic        [tkh_pkg::TAG_IN_W-1:0]  read_tag;

    modport source (output valid, accepted, min_key, held_count, read_valid, read_key,
                    read_tag, input ready);
    modport sink   (input valid, accepted, min_key, held_count, read_valid, read_key,
                    read_tag, output ready);
endinterface

interface tkh_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tkh_pkg::KEEP_W-1:0]       keep_count;

    modport source (output valid, keep_count, input ready);
    modport sink   (input valid, keep_count, output ready);
endinterface

/* hw/rtl/tkh_ram.sv */
module tkh_ram #(
    parameter int WIDTH = tkh_pkg::KEY_W + tkh_pkg::TAG_BITS_DEF,
    parameter int DEPTH = tkh_pkg::HEAP_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hw/rtl/top_k_min_heap_selector_unit.sv */
// Top-K selector: keeps the K largest keys offered, each with a tag, in a binary min-heap.
// Channels: i_in takes items (op, key, tag_id, slot), o_out returns one result per item,
// i_cfg writes keep_count (K) and is always ready. Each channel transfers on valid && ready.
// Ops: offer inserts (heap not full) or replaces the root when the key beats it; read
// returns the entry at a heap slot; clear empties the heap; any other code reports status.
// One item is worked at a time: the next item can transfer only once the result has been
// loaded into the output register. Read, clear, dropped offers: the transfer moves to the
// response state, which loads the result into the output register. An insert walks up one
// heap level per cycle and a root replace walks down one level per cycle, since key and tag
// sit in one RAM with a write port and two registered read ports. The walk writes the new
// entry where it stops; when it reaches the root or a leaf, a put state writes it instead.
// The response state then loads the result into the output register.
// Receiver stall: the result holds in the output register; the block takes one more item
// and works it, then waits with that result until the register frees up.
// Reset: heap empty, K = 64, no result pending. The heap RAM needs no clearing; slots at
// or above the count are never read back.
module top_k_min_heap_selector_unit #(
    parameter int HEAP_DEPTH = tkh_pkg::HEAP_DEPTH_DEF,
    parameter int TAG_BITS   = tkh_pkg::TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkh_item_if.sink    i_in,
    tkh_res_if.source   o_out,
    tkh_cfg_if.sink     i_cfg
);

`include "assert_macros.svh"

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int XW = CW + 1;
    localparam int EW = CW + tkh_pkg::KEEP_W + tkh_pkg::SLOT_W;
    localparam int KW = tkh_pkg::KEY_W;
    localparam int MW = KW + TAG_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UP   = 5'b00010,
        S_DN   = 5'b00100,
        S_PUT  = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [tkh_pkg::KEEP_W-1:0] r_keep;
    logic signed [KW-1:0]  r_root, n_root;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_ra_a, n_ra_a;
    logic [AW-1:0]         r_ra_b, n_ra_b;
    logic signed [KW-1:0]  r_new_key, n_new_key;
    logic [TAG_BITS-1:0]   r_new_tag, n_new_tag;
    logic                  r_acc, n_acc;
    logic                  r_rvalid, n_rvalid;

    logic                  r_out_valid;
    logic                  r_o_accepted;
    logic signed [KW-1:0]  r_o_min_key;
    logic [tkh_pkg::HELD_W-1:0] r_o_held;
    logic                  r_o_rvalid;
    logic signed [KW-1:0]  r_o_rkey;
    logic [tkh_pkg::TAG_IN_W-1:0] r_o_rtag;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [MW-1:0]         ram_wdata;
    logic [MW-1:0]         ram_rd_a;
    logic [MW-1:0]         ram_rd_b;
    logic signed [KW-1:0]  rd_a_key;
    logic signed [KW-1:0]  rd_b_key;
    logic [TAG_BITS-1:0]   rd_a_tag;

    logic [EW-1:0]         keep_ext;
    logic [EW-1:0]         k_sat;
    logic                  not_full;
    logic                  in_xfer;
    logic                  ins_xfer;
    logic                  out_load;
    logic [AW-1:0]         up_grand;
    logic                  take_l;
    logic                  take_r;
    logic [AW-1:0]         dn_child;
    logic [XW-1:0]         dn_lc;
    logic [XW-1:0]         dn_rc;

    assign rd_a_key = $signed(ram_rd_a[MW-1 -: KW]);
    assign rd_b_key = $signed(ram_rd_b[MW-1 -: KW]);
    assign rd_a_tag = ram_rd_a[TAG_BITS-1:0];

    // Saturate K to 1..HEAP_DEPTH.
    always_comb begin
        keep_ext = EW'(r_keep);
        if (keep_ext == '0) begin
            k_sat = EW'(1);
        end else if (keep_ext > EW'(HEAP_DEPTH)) begin
            k_sat = EW'(HEAP_DEPTH);
        end else begin
            k_sat = keep_ext;
        end
    end

    assign not_full = EW'(r_count) < k_sat;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign ins_xfer = in_xfer && (i_in.op == tkh_pkg::OP_OFFER) && not_full;
    assign out_load = (r_state == S_RESP) && (!r_out_valid || o_out.ready);

    // Sift-up: r_ra_a holds the parent being compared.
    assign up_grand = (r_ra_a - AW'(1)) >> 1;

    // Sift-down: on a tie of two smaller children the right one wins.
    assign take_l   = (rd_a_key < r_new_key) && (rd_a_key < rd_b_key);
    assign take_r   = !take_l && (rd_b_key < r_new_key);
    assign dn_child = take_l ? r_ra_a : r_ra_b;
    assign dn_lc    = XW'({dn_child, 1'b0}) + XW'(1);
    assign dn_rc    = dn_lc + XW'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_root    = r_root;
        n_idx     = r_idx;
        n_ra_a    = r_ra_a;
        n_ra_b    = r_ra_b;
        n_new_key = r_new_key;
        n_new_tag = r_new_tag;
        n_acc     = r_acc;
        n_rvalid  = r_rvalid;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {r_new_key, r_new_tag};

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_acc     = 1'b0;
                    n_rvalid  = 1'b0;
                    n_new_key = i_in.key;
                    n_new_tag = TAG_BITS'(i_in.tag_id);
                    n_state   = S_RESP;
                    case (i_in.op)
                        tkh_pkg::OP_OFFER: begin
                            if (ins_xfer) begin
                                // Append at the end and walk toward the root.
                                n_acc   = 1'b1;
                                n_count = r_count + CW'(1);
                                n_idx   = AW'(r_count);
                                if (r_count == '0) begin
                                    n_state = S_PUT;
                                end else begin
                                    n_ra_a  = AW'((r_count - CW'(1)) >> 1);
                                    n_state = S_UP;
                                end
                            end else if (r_root < i_in.key) begin
                                // Replace the root and walk toward the leaves.
                                n_acc = 1'b1;
                                n_idx = '0;
                                if (r_count <= CW'(1)) begin
                                    n_state = S_PUT;
                                end else begin
                                    n_ra_a  = AW'(1);
                                    n_ra_b  = (r_count > CW'(2)) ? AW'(2) : AW'(1);
                                    n_state = S_DN;
                                end
                            end
                        end
                        tkh_pkg::OP_READ: begin
                            n_rvalid = (EW'(i_in.slot) < EW'(r_count)) &&
                                       (EW'(i_in.slot) < EW'(HEAP_DEPTH));
                            n_ra_a   = AW'(i_in.slot);
                        end
                        tkh_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UP: begin
                ram_we = 1'b1;
                if (r_new_key < rd_a_key) begin
                    // Move the parent down into the hole.
                    ram_wdata = ram_rd_a;
                    n_idx     = r_ra_a;
                    if (r_ra_a == '0) begin
                        n_state = S_PUT;
                    end else begin
                        n_ra_a = up_grand;
                    end
                end else begin
                    n_state = S_RESP;
                end
            end
            S_DN: begin
                ram_we = 1'b1;
                if (take_l || take_r) begin
                    // Move the smaller child up into the hole.
                    ram_wdata = take_l ? ram_rd_a : ram_rd_b;
                    n_idx     = dn_child;
                    if (dn_lc >= XW'(r_count)) begin
                        n_state = S_PUT;
                    end else begin
                        n_ra_a = AW'(dn_lc);
                        n_ra_b = (dn_rc < XW'(r_count)) ? AW'(dn_rc) : AW'(dn_lc);
                    end
                end else begin
                    n_state = S_RESP;
                end
            end
            S_PUT: begin
                ram_we  = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Mirror slot 0 so the root key is at hand without a RAM read.
        if (ram_we && (ram_waddr == '0)) begin
            n_root = $signed(ram_wdata[MW-1 -: KW]);
        end
    end

    tkh_ram #(
        .WIDTH (MW),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (n_ra_a),
        .i_raddr_b (n_ra_b),
        .o_rdata_a (ram_rd_a),
        .o_rdata_b (ram_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_keep      <= tkh_pkg::KEEP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                r_keep <= i_cfg.keep_count;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_root    <= n_root;
        r_idx     <= n_idx;
        r_ra_a    <= n_ra_a;
        r_ra_b    <= n_ra_b;
        r_new_key <= n_new_key;
        r_new_tag <= n_new_tag;
        r_acc     <= n_acc;
        r_rvalid  <= n_rvalid;
        if (out_load) begin
            r_o_accepted <= r_acc;
            r_o_min_key  <= (r_count != '0) ? r_root : '0;
            r_o_held     <= tkh_pkg::HELD_W'(r_count);
            r_o_rvalid   <= r_rvalid;
            r_o_rkey     <= r_rvalid ? rd_a_key : '0;
            r_o_rtag     <= r_rvalid ? tkh_pkg::TAG_IN_W'(rd_a_tag) : '0;
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.accepted   = r_o_accepted;
    assign o_out.min_key    = r_o_min_key;
    assign o_out.held_count = r_o_held;
    assign o_out.read_valid = r_o_rvalid;
    assign o_out.read_key   = r_o_rkey;
    assign o_out.read_tag   = r_o_rtag;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(HEAP_DEPTH))
    `ASSERT_IMPLY(a_up_not_root, i_clk, i_rst_n, r_state == S_UP, r_idx != '0)
    `ASSERT_IMPLY(a_dn_has_child, i_clk, i_rst_n, r_state == S_DN, r_count > CW'(1))
    `ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, ins_xfer, r_count == $past(r_count) + CW'(1))

endmodule
